// File: src/scf_pkg.sv
// package: shared constants, opcode codes and descriptor types of the servo command framer
package scf_pkg;

    localparam int MAX_SERVOS  = 31;

    localparam int OP_W        = 4;
    localparam int ID_W        = 5;
    localparam int SPEED_W     = 4;
    localparam int BYTE_W      = 8;
    localparam int CHECK_W     = 7;
    localparam int SAT_W       = 3;

    localparam int SLOTS       = 6;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0]  HEADER        = 8'hFF;
    localparam logic [BYTE_W-1:0]  POSREAD_BASE  = 8'hA0;
    localparam logic [BYTE_W-1:0]  CTRL_BASE     = 8'hC0;
    localparam logic [BYTE_W-1:0]  BREAK_ID      = 8'hDF;
    localparam logic [BYTE_W-1:0]  BREAK_ARG     = 8'h20;
    localparam logic [BYTE_W-1:0]  PASSIVE_ARG   = 8'h10;
    localparam logic [BYTE_W-1:0]  SET_BASE      = 8'hE0;
    localparam logic [BYTE_W-1:0]  CMD_BAUD      = 8'h08;
    localparam logic [BYTE_W-1:0]  CMD_GAIN      = 8'h09;
    localparam logic [BYTE_W-1:0]  CMD_GAINREAD  = 8'h0A;
    localparam logic [BYTE_W-1:0]  CMD_IDSET     = 8'h0C;
    localparam logic [BYTE_W-1:0]  CMD_BOUNDSET  = 8'h11;
    localparam logic [BYTE_W-1:0]  CMD_BOUNDREAD = 8'h12;
    localparam logic [BYTE_W-1:0]  ZERO_BYTE     = 8'h00;
    localparam logic [ID_W-1:0]    SYNC_ID       = 5'h1F;
    localparam logic [3:0]         WHEEL_CCW     = 4'h3;
    localparam logic [3:0]         WHEEL_CW      = 4'h4;
    localparam logic [SAT_W-1:0]   SPEED_SAT     = 3'd7;
    localparam logic [CHECK_W-1:0] CHECK_MASK    = 7'h7F;

    typedef enum logic [OP_W-1:0] {
        OP_MOVE      = 4'd0,
        OP_POSREAD   = 4'd1,
        OP_PASSIVE   = 4'd2,
        OP_BREAK     = 4'd3,
        OP_WHEEL     = 4'd4,
        OP_BAUD      = 4'd5,
        OP_GAINSET   = 4'd6,
        OP_IDSET     = 4'd7,
        OP_GAINREAD  = 4'd8,
        OP_BOUNDSET  = 4'd9,
        OP_BOUNDREAD = 4'd10,
        OP_SYNCSTART = 4'd11,
        OP_SYNCELEM  = 4'd12
    } t_opcode;

    typedef struct packed {
        logic [SLOTS-1:0][BYTE_W-1:0] bytes;
        logic [SLOTS-1:0]             lasts;
        logic [CNT_W-1:0]             count;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: src/scf_in_if.sv
// interface: command item channel
interface scf_in_if;
    logic                         valid;
    logic                         ready;
    logic [scf_pkg::OP_W-1:0]     opcode;
    logic [scf_pkg::ID_W-1:0]     servo_id;
    logic [scf_pkg::SPEED_W-1:0]  speed;
    logic                         direction;
    logic [scf_pkg::BYTE_W-1:0]   value_a;
    logic [scf_pkg::BYTE_W-1:0]   value_b;
    logic [scf_pkg::ID_W-1:0]     last_id;

    modport source (output valid, opcode, servo_id, speed, direction, value_a, value_b,
                    last_id, input ready);
    modport sink   (input valid, opcode, servo_id, speed, direction, value_a, value_b,
                    last_id, output ready);
endinterface

// File: src/scf_out_if.sv
// interface: packet byte channel
interface scf_out_if;
    logic                        valid;
    logic                        ready;
    logic [scf_pkg::BYTE_W-1:0]  tx_byte;
    logic                        last;

    modport source (output valid, tx_byte, last, input ready);
    modport sink   (input valid, tx_byte, last, output ready);
endinterface

// File: src/scf_front.sv
// front end: accepts commands, tracks sync state and builds packet descriptors
module scf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    scf_in_if.sink            i_in,
    input  scf_pkg::t_q_stat  i_q_stat,
    output scf_pkg::t_push    o_push,
    output logic              o_sync_open
);

    logic [scf_pkg::ID_W-1:0]    r_sync_left;
    logic [scf_pkg::ID_W-1:0]    n_sync_left;
    logic [scf_pkg::CHECK_W-1:0] r_sync_check;
    logic [scf_pkg::CHECK_W-1:0] n_sync_check;
    scf_pkg::t_desc              desc;
    logic                        emit;
    logic                        accept;
    logic [scf_pkg::SAT_W-1:0]   sat;
    logic [scf_pkg::ID_W-1:0]    lid;
    logic [scf_pkg::ID_W-1:0]    left_dec;
    logic [scf_pkg::CHECK_W-1:0] check_upd;

    function automatic logic [scf_pkg::BYTE_W-1:0] chk(
        input logic [scf_pkg::BYTE_W-1:0] a, input logic [scf_pkg::BYTE_W-1:0] b,
        input logic [scf_pkg::BYTE_W-1:0] c, input logic [scf_pkg::BYTE_W-1:0] d);
        logic [scf_pkg::BYTE_W-1:0] x;
        x = a ^ b ^ c ^ d;
        return {1'b0, x[scf_pkg::CHECK_W-1:0] & scf_pkg::CHECK_MASK};
    endfunction

    function automatic scf_pkg::t_desc oper(
        input logic [scf_pkg::BYTE_W-1:0] d1, input logic [scf_pkg::BYTE_W-1:0] d2);
        scf_pkg::t_desc d;
        d          = '0;
        d.bytes[0] = scf_pkg::HEADER;
        d.bytes[1] = d1;
        d.bytes[2] = d2;
        d.bytes[3] = chk(d1, d2, scf_pkg::ZERO_BYTE, scf_pkg::ZERO_BYTE);
        d.lasts[3] = 1'b1;
        d.count    = scf_pkg::CNT_W'(4);
        return d;
    endfunction

    function automatic scf_pkg::t_desc setp(
        input logic [scf_pkg::BYTE_W-1:0] d1, input logic [scf_pkg::BYTE_W-1:0] d2,
        input logic [scf_pkg::BYTE_W-1:0] d3, input logic [scf_pkg::BYTE_W-1:0] d4);
        scf_pkg::t_desc d;
        d          = '0;
        d.bytes[0] = scf_pkg::HEADER;
        d.bytes[1] = d1;
        d.bytes[2] = d2;
        d.bytes[3] = d3;
        d.bytes[4] = d4;
        d.bytes[5] = chk(d1, d2, d3, d4);
        d.lasts[5] = 1'b1;
        d.count    = scf_pkg::CNT_W'(6);
        return d;
    endfunction

    assign i_in.ready  = !i_q_stat.full;
    assign accept      = i_in.valid && i_in.ready;
    assign o_sync_open = (r_sync_left != '0);

    assign sat       = (i_in.speed > scf_pkg::SPEED_W'(scf_pkg::SPEED_SAT)) ? scf_pkg::SPEED_SAT
                                                    : i_in.speed[scf_pkg::SAT_W-1:0];
    assign lid       = (i_in.last_id >= scf_pkg::ID_W'(scf_pkg::MAX_SERVOS))
                       ? scf_pkg::ID_W'(scf_pkg::MAX_SERVOS - 1) : i_in.last_id;
    assign left_dec  = r_sync_left - scf_pkg::ID_W'(1);
    assign check_upd = r_sync_check ^ i_in.value_a[scf_pkg::CHECK_W-1:0];

    always_comb begin
        desc         = '0;
        emit         = 1'b0;
        n_sync_left  = r_sync_left;
        n_sync_check = r_sync_check;
        if (r_sync_left != '0) begin
            if (i_in.opcode == scf_pkg::OP_SYNCELEM) begin
                emit         = 1'b1;
                desc.bytes[0] = i_in.value_a;
                desc.count   = scf_pkg::CNT_W'(1);
                n_sync_left  = left_dec;
                n_sync_check = check_upd;
                if (left_dec == '0) begin
                    desc.bytes[1] = {1'b0, check_upd};
                    desc.lasts[1] = 1'b1;
                    desc.count    = scf_pkg::CNT_W'(2);
                    n_sync_check  = '0;
                end
            end
        end else begin
            emit = 1'b1;
            unique case (i_in.opcode)
                scf_pkg::OP_MOVE:      desc = oper({sat, i_in.servo_id}, i_in.value_a);
                scf_pkg::OP_POSREAD:   desc = oper(scf_pkg::POSREAD_BASE | 8'(i_in.servo_id),
                                                   scf_pkg::ZERO_BYTE);
                scf_pkg::OP_PASSIVE:   desc = oper(scf_pkg::CTRL_BASE | 8'(i_in.servo_id),
                                                   scf_pkg::PASSIVE_ARG);
                scf_pkg::OP_BREAK:     desc = oper(scf_pkg::BREAK_ID, scf_pkg::BREAK_ARG);
                scf_pkg::OP_WHEEL:     desc = oper(scf_pkg::CTRL_BASE | 8'(i_in.servo_id),
                                                   {i_in.direction ? scf_pkg::WHEEL_CW
                                                                   : scf_pkg::WHEEL_CCW,
                                                    i_in.speed});
                scf_pkg::OP_BAUD:      desc = setp(scf_pkg::SET_BASE | 8'(i_in.servo_id),
                                                   scf_pkg::CMD_BAUD, i_in.value_a,
                                                   i_in.value_a);
                scf_pkg::OP_GAINSET:   desc = setp(scf_pkg::SET_BASE | 8'(i_in.servo_id),
                                                   scf_pkg::CMD_GAIN, i_in.value_a,
                                                   i_in.value_b);
                scf_pkg::OP_IDSET:     desc = setp(scf_pkg::SET_BASE | 8'(i_in.servo_id),
                                                   scf_pkg::CMD_IDSET, i_in.value_a,
                                                   i_in.value_a);
                scf_pkg::OP_GAINREAD:  desc = setp(scf_pkg::SET_BASE | 8'(i_in.servo_id),
                                                   scf_pkg::CMD_GAINREAD, scf_pkg::ZERO_BYTE,
                                                   scf_pkg::ZERO_BYTE);
                scf_pkg::OP_BOUNDSET:  desc = setp(scf_pkg::SET_BASE | 8'(i_in.servo_id),
                                                   scf_pkg::CMD_BOUNDSET, i_in.value_a,
                                                   i_in.value_b);
                scf_pkg::OP_BOUNDREAD: desc = setp(scf_pkg::SET_BASE | 8'(i_in.servo_id),
                                                   scf_pkg::CMD_BOUNDREAD, scf_pkg::ZERO_BYTE,
                                                   scf_pkg::ZERO_BYTE);
                scf_pkg::OP_SYNCSTART: begin
                    desc.bytes[0] = scf_pkg::HEADER;
                    desc.bytes[1] = {sat, scf_pkg::SYNC_ID};
                    desc.bytes[2] = scf_pkg::BYTE_W'(lid) + scf_pkg::BYTE_W'(1);
                    desc.count    = scf_pkg::CNT_W'(3);
                    n_sync_left   = lid + scf_pkg::ID_W'(1);
                    n_sync_check  = '0;
                end
                default: emit = 1'b0;
            endcase
        end
    end

    assign o_push.valid = accept && emit;
    assign o_push.desc  = desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_left  <= '0;
            r_sync_check <= '0;
        end else if (accept) begin
            r_sync_left  <= n_sync_left;
            r_sync_check <= n_sync_check;
        end
    end

endmodule

// File: src/scf_queue.sv
// two-entry descriptor queue between front end and byte sequencer
module scf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scf_pkg::t_push    i_push,
    input  logic              i_pop,
    output scf_pkg::t_desc    o_desc,
    output scf_pkg::t_q_stat  o_stat
);

    scf_pkg::t_desc               r_mem [scf_pkg::QUEUE_DEPTH];
    logic [scf_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [scf_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [scf_pkg::QCNT_W-1:0]   r_count;

    assign o_desc       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == scf_pkg::QCNT_W'(scf_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == scf_pkg::QPTR_W'(scf_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + scf_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == scf_pkg::QPTR_W'(scf_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + scf_pkg::QPTR_W'(1);
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + scf_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - scf_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: src/scf_back.sv
// back end: steps through a descriptor and sends one byte per transfer
module scf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scf_pkg::t_desc  i_desc,
    input  logic            i_q_valid,
    output logic            o_pop,
    scf_out_if.source       o_out
);

    scf_pkg::t_desc              r_desc;
    logic [scf_pkg::IDX_W-1:0]   r_idx;
    logic                        r_busy;
    logic                        r_out_valid;
    logic [scf_pkg::BYTE_W-1:0]  r_out_byte;
    logic                        r_out_last;
    logic                        adv;
    logic                        fin;
    logic                        load;

    assign adv   = !r_out_valid || o_out.ready;
    assign fin   = r_busy && adv &&
                   (r_idx == scf_pkg::IDX_W'(r_desc.count - scf_pkg::CNT_W'(1)));
    assign load  = i_q_valid && (!r_busy || fin);
    assign o_pop = load;

    assign o_out.valid   = r_out_valid;
    assign o_out.tx_byte = r_out_byte;
    assign o_out.last    = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= r_busy;
                if (r_busy) begin
                    r_out_byte <= r_desc.bytes[r_idx];
                    r_out_last <= r_desc.lasts[r_idx];
                end
            end
            if (load) begin
                r_desc <= i_desc;
                r_idx  <= '0;
                r_busy <= 1'b1;
            end else if (fin) begin
                r_busy <= 1'b0;
            end else if (adv && r_busy) begin
                r_idx  <= r_idx + scf_pkg::IDX_W'(1);
            end
        end
    end

endmodule

// File: src/servo_command_framer.sv
// top level: servo command framer, front end, descriptor queue and byte sequencer
//
//  channel  direction  content
//  i_in     sink       opcode, servo_id, speed, direction, value_a, value_b, last_id
//  o_out    source     tx_byte, last
//
// one byte leaves per cycle while the output is ready; a command packet holds 4 or 6 bytes, sync items 1 to 3
// the front end takes a command every cycle while the two-entry queue has room
// the byte sequencer runs back to back across packets with the output register held
// reset clears sync state, queue pointers and the sequencer
// a stalled output holds its byte; the queue then fills and ready drops
module servo_command_framer (
    input  logic   i_clk,
    input  logic   i_rst_n,
    scf_in_if.sink    i_in,
    scf_out_if.source o_out
);

    scf_pkg::t_push    push;
    scf_pkg::t_desc    q_desc;
    scf_pkg::t_q_stat  q_stat;
    logic              pop;
    logic              sync_open;

    scf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_sync_open (sync_open)
    );

    scf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_desc  (q_desc),
        .o_stat  (q_stat)
    );

    scf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_desc    (q_desc),
        .i_q_valid (!q_stat.empty),
        .o_pop     (pop),
        .o_out     (o_out)
    );

`ifndef SYNTHESIS
    a_q_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty together");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> !q_stat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_sync_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sync_open && push.valid) |->
            (push.desc.count == scf_pkg::CNT_W'(1) || push.desc.count == scf_pkg::CNT_W'(2)))
        else $error("sync element descriptor of wrong length");
`endif

endmodule
